[rtl/rbj_pkg.sv]
// ----------------------------------------------------------------------------
// rbj_pkg
// shared widths, hash constants, register indexes and pipeline types for the
// retry backoff unit
// ----------------------------------------------------------------------------
package rbj_pkg;

  localparam int DW   = 62;            // delay, base and cap width
  localparam int JFB  = 16;            // jitter fraction bits
  localparam int JW   = JFB + 1;       // jitter register width
  localparam int AW   = 32;            // attempt count width
  localparam int HW   = 64;            // hash word width
  localparam int UW   = 53;            // hash fraction width
  localparam int PW   = DW + JW;       // delay times jitter width
  localparam int SHW  = 2 * DW - 1;    // widest shifted delay
  localparam int SAW  = $clog2(DW);    // shift amount width
  localparam int DL   = DW / 2;        // low half of the delay
  localparam int LB   = 27;            // limb width of the shave multiplier
  localparam int CIW  = 2;             // config index width

  localparam logic [HW-1:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [HW-1:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
  localparam logic [HW-1:0] MIX_M2 = 64'h94D049BB133111EB;

  localparam logic [JW-1:0] JIT_ONE = {1'b1, {JFB{1'b0}}};

  localparam logic [DW-1:0] BASE_RST = 62'd1000000000;
  localparam logic [DW-1:0] CAP_RST  = 62'd3600000000000;

  localparam logic [CIW-1:0] REG_BASE = 2'd0;
  localparam logic [CIW-1:0] REG_CAP  = 2'd1;
  localparam logic [CIW-1:0] REG_JIT  = 2'd2;

  typedef struct packed {
    logic          valid;
    logic [DW-1:0] dly;
    logic [PW-1:0] djp;
  } rbj_scaled_t;

endpackage

[rtl/rbj_mix.sv]
// ----------------------------------------------------------------------------
// rbj_mix
// splitmix64 finalizer, four register stages, yields the 53-bit jitter fraction
// ----------------------------------------------------------------------------
module rbj_mix import rbj_pkg::*; (
  input  logic          clk,
  input  logic [HW-1:0] seed_i,   // seed already offset by the golden constant
  output logic [UW-1:0] frac_o
);

  logic [HW-1:0] y, w, h;
  logic [HW-1:0] pa_ll_r, pa_ll_nxt;
  logic [31:0]   pa_lh_r, pa_lh_nxt, pa_hl_r, pa_hl_nxt;
  logic [HW-1:0] z_r, z_nxt;
  logic [HW-1:0] pb_ll_r, pb_ll_nxt;
  logic [31:0]   pb_lh_r, pb_lh_nxt, pb_hl_r, pb_hl_nxt;
  logic [HW-1:0] h_r, h_nxt;

  // low 64 bits of a 64x64 product from three 32x32 partial products
  always_comb begin
    y         = seed_i ^ (seed_i >> 30);
    pa_ll_nxt = HW'(y[31:0]) * HW'(MIX_M1[31:0]);
    pa_lh_nxt = 32'(y[31:0] * MIX_M1[63:32]);
    pa_hl_nxt = 32'(y[63:32] * MIX_M1[31:0]);
    z_nxt     = pa_ll_r + {pa_lh_r + pa_hl_r, 32'h0};
    w         = z_r ^ (z_r >> 27);
    pb_ll_nxt = HW'(w[31:0]) * HW'(MIX_M2[31:0]);
    pb_lh_nxt = 32'(w[31:0] * MIX_M2[63:32]);
    pb_hl_nxt = 32'(w[63:32] * MIX_M2[31:0]);
    h_nxt     = pb_ll_r + {pb_lh_r + pb_hl_r, 32'h0};
    h         = h_r ^ (h_r >> 31);
    frac_o    = h[HW-1:HW-UW];
  end

  always_ff @(posedge clk) begin
    pa_ll_r <= pa_ll_nxt;
    pa_lh_r <= pa_lh_nxt;
    pa_hl_r <= pa_hl_nxt;
    z_r     <= z_nxt;
    pb_ll_r <= pb_ll_nxt;
    pb_lh_r <= pb_lh_nxt;
    pb_hl_r <= pb_hl_nxt;
    h_r     <= h_nxt;
  end

endmodule

[rtl/rbj_scale.sv]
// ----------------------------------------------------------------------------
// rbj_scale
// capped doubling as a clamped shift, then delay times jitter, four stages
// ----------------------------------------------------------------------------
module rbj_scale import rbj_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [DW-1:0] base_i,   // base already held to the cap
  input  logic [AW-1:0] shift_i,  // doublings asked for
  input  logic [DW-1:0] cap_i,
  input  logic [JW-1:0] jit_i,    // saturated to one
  output rbj_scaled_t   scaled_o
);

  logic [3:0]       v_r, v_nxt;
  logic [SHW-1:0]   sh_r, sh_nxt;
  logic             sat_r, sat_nxt;
  logic [DW-1:0]    cap_r;
  logic [JW-1:0]    jit2_r, jit3_r;
  logic [DW-1:0]    d3_r, d3_nxt, d4_r, d5_r;
  logic [DL+JW-1:0] dj_lo_r, dj_lo_nxt;
  logic [DL+JW-1:0] dj_hi_r, dj_hi_nxt;
  logic [PW-1:0]    djp_r, djp_nxt;
  logic             over;

  always_comb begin
    v_nxt   = {v_r[2:0], valid_i};
    sh_nxt  = SHW'(base_i) << shift_i[SAW-1:0];
    // any nonzero base doubled that often is past every cap
    sat_nxt = (shift_i >= AW'(DW)) && (base_i != '0);
    over    = sat_r || (sh_r[SHW-1:DW] != '0) || (sh_r[DW-1:0] >= cap_r);
    d3_nxt  = over ? cap_r : sh_r[DW-1:0];
    dj_lo_nxt = d3_r[DL-1:0] * jit3_r;
    dj_hi_nxt = d3_r[DW-1:DL] * jit3_r;
    djp_nxt = PW'(dj_lo_r) + (PW'(dj_hi_r) << DL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    sat_r   <= sat_nxt;
    cap_r   <= cap_i;
    jit2_r  <= jit_i;
    d3_r    <= d3_nxt;
    jit3_r  <= jit2_r;
    dj_lo_r <= dj_lo_nxt;
    dj_hi_r <= dj_hi_nxt;
    d4_r    <= d3_r;
    djp_r   <= djp_nxt;
    d5_r    <= d4_r;
  end

  assign scaled_o = '{valid: v_r[3], dly: d5_r, djp: djp_r};

endmodule

[rtl/rbj_shave.sv]
// ----------------------------------------------------------------------------
// rbj_shave
// exact floor of delay * jitter * fraction and the final subtract, five stages
// ----------------------------------------------------------------------------
module rbj_shave import rbj_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  rbj_scaled_t   scaled_i,
  input  logic [UW-1:0] frac_i,
  output logic          valid_o,
  output logic [DW-1:0] delay_o
);

  localparam int PPW = 2 * LB;
  localparam int SW  = PPW + 1;
  localparam int QW  = SW + LB + 1;
  localparam int FW  = PW + UW + 1;

  logic [4:0]     v_r, v_nxt;
  logic [DW-1:0]  d6_r, d7_r, d8_r, d9_r;
  logic [PPW-1:0] m00_r, m00_nxt, m10_r, m10_nxt, m01_r, m01_nxt;
  logic [PPW-1:0] m11_r, m11_nxt, m20_r, m20_nxt, m21_r, m21_nxt;
  logic [SW-1:0]  s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic [QW-1:0]  qa_r, qa_nxt, qb_r, qb_nxt;
  logic [FW-1:0]  full;
  logic [DW-1:0]  cut_r, cut_nxt;
  logic [DW-1:0]  out_r, out_nxt;

  always_comb begin
    v_nxt   = {v_r[3:0], scaled_i.valid};
    // limb products, none wider than 27x27
    m00_nxt = PPW'(scaled_i.djp[LB-1:0]) * PPW'(frac_i[LB-1:0]);
    m10_nxt = PPW'(scaled_i.djp[2*LB-1:LB]) * PPW'(frac_i[LB-1:0]);
    m01_nxt = PPW'(scaled_i.djp[LB-1:0]) * PPW'(frac_i[UW-1:LB]);
    m11_nxt = PPW'(scaled_i.djp[2*LB-1:LB]) * PPW'(frac_i[UW-1:LB]);
    m20_nxt = PPW'(scaled_i.djp[PW-1:2*LB]) * PPW'(frac_i[LB-1:0]);
    m21_nxt = PPW'(scaled_i.djp[PW-1:2*LB]) * PPW'(frac_i[UW-1:LB]);
    // gather by weight
    s0_nxt  = SW'(m00_r);
    s1_nxt  = SW'(m10_r) + SW'(m01_r);
    s2_nxt  = SW'(m20_r) + SW'(m11_r);
    s3_nxt  = SW'(m21_r);
    qa_nxt  = QW'(s0_r) + (QW'(s1_r) << LB);
    qb_nxt  = QW'(s2_r) + (QW'(s3_r) << LB);
    full    = FW'(qa_r) + (FW'(qb_r) << (2 * LB));
    cut_nxt = full[UW+JFB +: DW];
    out_nxt = (cut_r >= d9_r) ? '0 : d9_r - cut_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m00_r <= m00_nxt;
    m10_r <= m10_nxt;
    m01_r <= m01_nxt;
    m11_r <= m11_nxt;
    m20_r <= m20_nxt;
    m21_r <= m21_nxt;
    d6_r  <= scaled_i.dly;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    d7_r  <= d6_r;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    d8_r  <= d7_r;
    cut_r <= cut_nxt;
    d9_r  <= d8_r;
    out_r <= out_nxt;
  end

  assign valid_o = v_r[4];
  assign delay_o = out_r;

endmodule

[rtl/retry_backoff_with_jitter_unit.sv]
// ----------------------------------------------------------------------------
// retry_backoff_with_jitter_unit
// a word runs through the entry stage, mix and scale, then shave to out_valid
// throughput: one word per cycle, set by the fully pipelined multipliers
// busy never rises and the result side cannot stall, so nothing is held off
// synchronous active-low reset clears the valid chain and loads the register
// defaults; payload registers are not reset
// ----------------------------------------------------------------------------
module retry_backoff_with_jitter_unit import rbj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic [AW-1:0]        in_attempt_count,
  input  logic signed [HW-1:0] in_job_ident,
  input  logic signed [HW-1:0] in_time_now,
  // result side, one strobe per word
  output logic                 out_valid,
  output logic [DW-1:0]        out_delay_ns,
  // register writes
  input  logic                 cfg_we,
  input  logic [CIW-1:0]       cfg_index,
  input  logic [DW-1:0]        cfg_data
);

  // configuration registers
  logic [DW-1:0] base_r, base_nxt;
  logic [DW-1:0] cap_r, cap_nxt;
  logic [JW-1:0] jit_r, jit_nxt;

  // entry stage
  logic          accept;
  logic          v1_r;
  logic [HW-1:0] seed_r, seed_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [DW-1:0] d0_r, d0_nxt;
  logic [DW-1:0] cap1_r;
  logic [JW-1:0] jit1_r, jit1_nxt;

  logic [UW-1:0] frac;
  rbj_scaled_t   scaled;

  // every cycle can take a word
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // register file, writes beyond the list fall through
  always_comb begin
    base_nxt = base_r;
    cap_nxt  = cap_r;
    jit_nxt  = jit_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_BASE: base_nxt = cfg_data;
        REG_CAP:  cap_nxt  = cfg_data;
        REG_JIT:  jit_nxt  = cfg_data[JW-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      cap_r  <= CAP_RST;
      jit_r  <= '0;
      v1_r   <= 1'b0;
    end else begin
      base_r <= base_nxt;
      cap_r  <= cap_nxt;
      jit_r  <= jit_nxt;
      v1_r   <= accept;
    end
  end

  // seed xor, golden offset, and the per-word operands
  always_comb begin
    seed_nxt = ($unsigned(in_job_ident) ^ $unsigned(in_time_now)
                ^ {in_attempt_count, 32'h0}) + GOLDEN;
    // zero attempts behaves like one
    n_nxt    = (in_attempt_count == '0) ? '0 : in_attempt_count - AW'(1);
    d0_nxt   = (base_r < cap_r) ? base_r : cap_r;
    jit1_nxt = (jit_r > JIT_ONE) ? JIT_ONE : jit_r;
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    n_r    <= n_nxt;
    d0_r   <= d0_nxt;
    cap1_r <= cap_r;
    jit1_r <= jit1_nxt;
  end

  // hash and delay run side by side, both four stages deep
  rbj_mix u_mix (
    .clk    (clk),
    .seed_i (seed_r),
    .frac_o (frac)
  );

  rbj_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (v1_r),
    .base_i   (d0_r),
    .shift_i  (n_r),
    .cap_i    (cap1_r),
    .jit_i    (jit1_r),
    .scaled_o (scaled)
  );

  // shave product and subtract, ends in the output register
  rbj_shave u_shave (
    .clk      (clk),
    .rst_n    (rst_n),
    .scaled_i (scaled),
    .frac_i   (frac),
    .valid_o  (out_valid),
    .delay_o  (out_delay_ns)
  );

endmodule
